>>> rtl/cph_pkg.sv
// Shared types, widths and codes for the capture period histogram.
`timescale 1ns / 1ps
package cph_pkg;

    // Default geometry of the histogram and the timer.
    localparam int BIN_SPAN_DEF   = 100;
    localparam int TIME_WIDTH_DEF = 32;

    // Field widths fixed by the item format.
    localparam int ACT_W      = 2;
    localparam int IDX_W      = 7;
    localparam int CNT_W      = 16;
    localparam int LOW_W      = 14;
    localparam int OUT_TIME_W = 32;

    // Stream word widths, packed from the lowest bit up and padded to bytes.
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = ACT_W;
    localparam int M_USED_W  = 3 * CNT_W + OUT_TIME_W + 2;
    localparam int M_TDATA_W = 88;
    localparam int M_PAD_W   = M_TDATA_W - M_USED_W;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_LOW_LIMIT    = 1'b0;
    localparam t_cfg_idx CFG_SAMPLE_LIMIT = 1'b1;

    // Register reset values.
    localparam logic [LOW_W-1:0] LOW_LIMIT_RST    = 14'd950;
    localparam logic [CNT_W-1:0] SAMPLE_LIMIT_RST = 16'd1000;
    localparam logic [CNT_W-1:0] COUNT_MAX        = 16'hFFFF;

    // Action codes carried in tuser; the fourth code is unused.
    typedef logic [ACT_W-1:0] t_action;
    localparam t_action ACT_CAPTURE = 2'd0;
    localparam t_action ACT_START   = 2'd1;
    localparam t_action ACT_READ    = 2'd2;

    // Saturating increment shared by the bin counts and the in-range total.
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == COUNT_MAX) ? v : v + CNT_W'(1);
    endfunction

endpackage

>>> rtl/cph_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module cph_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 101
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and read-first registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/capture_period_histogram.sv
// Top level of the capture period histogram: capture stage, bin pipeline, output register.
//
//  Channel   Direction  Handshake                 Contents
//  s         in         i_s_tvalid / o_s_tready   tuser: action; tdata: capture_time, bin_index
//  m         out        o_m_tvalid / i_m_tready   tdata: counts, interval, flags
//  cfg       in         i_cfg_valid / o_cfg_ready register index and write data
//
// One word is accepted per clock cycle while the output is not stalled; its result is registered
// in the first stage, the second stage and the output register. The rate is set by the bin
// read-modify-write, which spans the memory read and the update, with the last write
// forwarded to the next word. Reset is synchronous; a start word clears the bin valid
// flags at once, so there is no clearing pass. A stall on the output fills the
// two pipeline stages and the output register before tready drops.
`timescale 1ns / 1ps
module capture_period_histogram #(
    parameter int BIN_SPAN   = cph_pkg::BIN_SPAN_DEF,
    parameter int TIME_WIDTH = cph_pkg::TIME_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input stream.
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [cph_pkg::S_TDATA_W-1:0] i_s_tdata,  // capture_time[31:0], bin_index[38:32]
    input  logic [cph_pkg::S_TUSER_W-1:0] i_s_tuser,  // action[1:0]
    // Result stream.
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [cph_pkg::M_TDATA_W-1:0] o_m_tdata,  // bin_count[15:0], in_range_total[31:16],
                                                      // samples_taken[47:32], interval[79:48],
                                                      // in_window[80], run_done[81]
    // Configuration writes.
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [cph_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [cph_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import cph_pkg::*;

    localparam int DEPTH  = BIN_SPAN + 1;
    localparam int ADDR_W = $clog2(DEPTH);

    // Configuration registers.
    logic [LOW_W-1:0] r_low_limit;
    logic [CNT_W-1:0] r_sample_limit;

    // Run state kept at the input.
    logic [TIME_WIDTH-1:0] r_prev;
    logic                  r_have_ref;
    logic                  r_armed;
    logic [CNT_W-1:0]      r_samples;
    logic [CNT_W-1:0]      n_samples;

    // First stage.
    logic                  r_s1_valid;
    logic                  r_s1_start;
    logic                  r_s1_read;
    logic                  r_s1_measure;
    logic [TIME_WIDTH-1:0] r_s1_diff;
    logic [IDX_W-1:0]      r_s1_index;
    logic [CNT_W-1:0]      r_s1_samples;

    // Second stage.
    logic                  r_s2_valid;
    logic                  r_s2_start;
    logic                  r_s2_hit;
    logic                  r_s2_rd_ok;
    logic [ADDR_W-1:0]     r_s2_addr;
    logic                  r_s2_vbit;
    logic [TIME_WIDTH-1:0] r_s2_diff;
    logic [CNT_W-1:0]      r_s2_samples;
    logic                  r_s2_done;

    // Bin bookkeeping.
    logic [DEPTH-1:0]  r_bin_vld;
    logic              r_lw_en;
    logic [ADDR_W-1:0] r_lw_addr;
    logic [CNT_W-1:0]  r_lw_data;
    logic [CNT_W-1:0]  r_window_total;
    logic [CNT_W-1:0]  n_window_total;

    // Output register.
    logic                 r_out_valid;
    logic [M_TDATA_W-1:0] r_out_data;

    // Handshake and stage enables.
    logic en_out, en2, en1, s_fire, s2_move;

    // Input decode.
    t_action               act;
    logic [TIME_WIDTH-1:0] now_t;
    logic [IDX_W-1:0]      idx_in;
    logic                  cap_ok, is_cap, is_start, is_read, measure;
    logic [TIME_WIDTH-1:0] diff_in;

    // First stage arithmetic.
    logic [TIME_WIDTH:0]   s1_off;
    logic                  s1_hit, s1_rd_ok, s1_done, s1_vbit;
    logic [ADDR_W-1:0]     s1_addr;

    // Second stage arithmetic.
    logic [CNT_W-1:0] ram_rdata, base_count, n_count, bin_count_out;
    logic             wr_en;

    assign en_out  = !r_out_valid || i_m_tready;
    assign en2     = !r_s2_valid || en_out;
    assign en1     = !r_s1_valid || en2;
    assign s_fire  = i_s_tvalid && en1;
    assign s2_move = r_s2_valid && en_out;

    assign o_s_tready  = en1;
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_limit    <= LOW_LIMIT_RST;
            r_sample_limit <= SAMPLE_LIMIT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LOW_LIMIT:    r_low_limit    <= i_cfg_data[LOW_W-1:0];
                CFG_SAMPLE_LIMIT: r_sample_limit <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Decode the incoming word and form the interval against the reference.
    always_comb begin
        act      = i_s_tuser;
        now_t    = i_s_tdata[TIME_WIDTH-1:0];
        idx_in   = i_s_tdata[OUT_TIME_W +: IDX_W];
        is_cap   = (act == ACT_CAPTURE);
        is_start = (act == ACT_START);
        is_read  = (act == ACT_READ);
        cap_ok   = r_armed && (r_samples < r_sample_limit);
        measure  = is_cap && cap_ok && r_have_ref;
        diff_in  = measure ? (now_t - r_prev) : '0;
        n_samples = r_samples;
        if (is_start) begin
            n_samples = '0;
        end else if (measure) begin
            n_samples = r_samples + CNT_W'(1);
        end
    end

    // Run state updates at the input.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev     <= '0;
            r_have_ref <= 1'b0;
            r_armed    <= 1'b0;
            r_samples  <= '0;
        end else if (s_fire) begin
            r_samples <= n_samples;
            if (is_start) begin
                r_prev     <= '0;
                r_have_ref <= 1'b0;
                r_armed    <= 1'b1;
            end else if (is_cap && cap_ok) begin
                r_prev     <= now_t;
                r_have_ref <= 1'b1;
            end
        end
    end

    // First stage registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en1) begin
            r_s1_valid <= s_fire;
        end
        if (en1) begin
            r_s1_start   <= is_start;
            r_s1_read    <= is_read;
            r_s1_measure <= measure;
            r_s1_diff    <= diff_in;
            r_s1_index   <= idx_in;
            r_s1_samples <= n_samples;
        end
    end

    // Window test and bin address.
    always_comb begin
        s1_off   = {1'b0, r_s1_diff} - (TIME_WIDTH + 1)'(r_low_limit);
        s1_hit   = r_s1_measure && !s1_off[TIME_WIDTH]
                   && (s1_off[TIME_WIDTH-1:0] <= TIME_WIDTH'(BIN_SPAN));
        s1_rd_ok = r_s1_read && (r_s1_index <= IDX_W'(BIN_SPAN));
        s1_addr  = s1_hit ? s1_off[ADDR_W-1:0] : r_s1_index[ADDR_W-1:0];
        s1_done  = (r_s1_samples >= r_sample_limit);
        s1_vbit  = r_bin_vld[s1_addr];
    end

    // Second stage registers; a start leaving the stage masks stale valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en2) begin
            r_s2_valid <= r_s1_valid;
        end
        if (en2) begin
            r_s2_start   <= r_s1_start;
            r_s2_hit     <= s1_hit;
            r_s2_rd_ok   <= s1_rd_ok;
            r_s2_addr    <= s1_addr;
            r_s2_vbit    <= s1_vbit && !(r_s2_valid && r_s2_start);
            r_s2_diff    <= r_s1_diff;
            r_s2_samples <= r_s1_samples;
            r_s2_done    <= s1_done;
        end
    end

    cph_ram #(
        .WIDTH (CNT_W),
        .DEPTH (DEPTH)
    ) u_bin_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_s2_addr),
        .i_wr_data (n_count),
        .i_rd_en   (en2),
        .i_rd_addr (s1_addr),
        .o_rd_data (ram_rdata)
    );

    // Bin update with forwarding of the write made as this word was read.
    always_comb begin
        if (r_lw_en && (r_lw_addr == r_s2_addr)) begin
            base_count = r_lw_data;
        end else if (r_s2_vbit) begin
            base_count = ram_rdata;
        end else begin
            base_count = '0;
        end
        n_count       = sat_inc(base_count);
        wr_en         = s2_move && r_s2_hit;
        bin_count_out = r_s2_rd_ok ? base_count : '0;
        n_window_total = r_window_total;
        if (r_s2_start) begin
            n_window_total = '0;
        end else if (r_s2_hit) begin
            n_window_total = sat_inc(r_window_total);
        end
    end

    // Bin valid flags, forwarding register and window total.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_vld      <= '0;
            r_lw_en        <= 1'b0;
            r_window_total <= '0;
        end else begin
            if (s2_move && r_s2_start) begin
                r_bin_vld <= '0;
            end else if (wr_en) begin
                r_bin_vld[r_s2_addr] <= 1'b1;
            end
            if (en2) begin
                r_lw_en <= wr_en;
            end
            if (s2_move) begin
                r_window_total <= n_window_total;
            end
        end
        if (en2) begin
            r_lw_addr <= r_s2_addr;
            r_lw_data <= n_count;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en_out) begin
            r_out_valid <= r_s2_valid;
        end
        if (s2_move) begin
            r_out_data <= {M_PAD_W'(0), r_s2_done, r_s2_hit, OUT_TIME_W'(r_s2_diff),
                           r_s2_samples, n_window_total, bin_count_out};
        end
    end

endmodule

>>> rtl/cph_checker.sv
// Port-level checker for the capture period histogram, bound to the top level.
`timescale 1ns / 1ps
module cph_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready,
    input logic [cph_pkg::M_TDATA_W-1:0] o_m_tdata
);
    import cph_pkg::*;

    logic [CNT_W-1:0]      bin_count, total, samples;
    logic [OUT_TIME_W-1:0] interval;
    logic                  in_window;

    assign bin_count = o_m_tdata[CNT_W-1:0];
    assign total     = o_m_tdata[CNT_W +: CNT_W];
    assign samples   = o_m_tdata[2*CNT_W +: CNT_W];
    assign interval  = o_m_tdata[3*CNT_W +: OUT_TIME_W];
    assign in_window = o_m_tdata[3*CNT_W + OUT_TIME_W];

    // No result leaves the block right after reset.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("result word valid after reset");

    // A stalled result word stays put.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result word changed");

    // A counted interval shows up in the in-range total.
    a_hit_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && in_window |-> total != '0)
        else $error("counted interval with zero in-range total");

    // The in-range total never passes the number of measured intervals.
    a_total_le: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> total <= samples)
        else $error("in-range total exceeds samples taken");

    // A bin count only comes with a read, never with a measured interval.
    a_read_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && bin_count != '0 |-> interval == '0 && !in_window)
        else $error("bin count on a capture word");

endmodule

bind capture_period_histogram cph_checker u_cph_checker (.*);
